@@ src/gcsf_pkg.sv @@
// ----------------------------------------------------------------------------
// gcsf_pkg: greedy compatible split filter package
// Sizes, word types, verdict codes and controller states shared by the
// filter core, its checker and the test bench.
// ----------------------------------------------------------------------------
`default_nettype none

package gcsf_pkg;

  localparam int MAX_SPLITS = 64;   // split store depth
  localparam int LEAF_BITS  = 64;   // widest leaf set handled (<= 64)

  localparam int SPLIT_W = 64;
  localparam int OCC_W   = 16;
  localparam int LEAF_W  = 7;
  localparam int SCNT_W  = 7;       // stored_count field width
  localparam int CNT_W   = $clog2(MAX_SPLITS + 1);
  localparam int ADDR_W  = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_EXT_MODE  = 2'd1,
    REG_LEAF_CNT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    VERD_MAJORITY   = 3'd0,
    VERD_COMPATIBLE = 3'd1,
    VERD_BELOW_THR  = 3'd2,
    VERD_CONFLICT   = 3'd3,
    VERD_FULL       = 3'd4
  } verdict_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } gcsf_state_t;

  typedef struct packed {
    logic [SPLIT_W-1:0] split_bits;
    logic [OCC_W-1:0]   occurrence;
    logic               new_set;
  } split_word_t;

  typedef struct packed {
    logic              accepted;
    logic [2:0]        verdict;
    logic [SCNT_W-1:0] stored_count;
  } result_word_t;

endpackage

`default_nettype wire

@@ src/greedy_compatible_split_filter_core.sv @@
// ----------------------------------------------------------------------------
// greedy_compatible_split_filter_core: extended majority-rule split filter
// Stores majority splits, then, in extended mode, greedily adds later splits
// that pass the four-gamete test against every stored split.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------
//  input     | start & !busy       | split_in  (split_bits, occurrence, new_set)
//  result    | done, 1-cycle pulse | result    (accepted, verdict, stored_count)
//  config    | cfg_we              | cfg_index, cfg_data
//
//  A majority split, a plain-mode rejection or an extended-mode split
//  facing an empty store is settled at the accept edge; its result word shows
//  up the next cycle, and a new word can be taken in that same cycle.
//  Otherwise busy stays high while the scan reads the stored entries, one
//  store read per cycle, waits for the last read data and then settles the
//  verdict; the result word shows up in the first cycle busy is low. Reset
//  clears the phase, fill count and control flags and loads the config
//  defaults; the store itself needs no clearing since only entries below the
//  fill count are ever checked. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_compatible_split_filter_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // split words
  input  wire logic                             start,
  output logic                                  busy,
  input  wire gcsf_pkg::split_word_t            split_in,
  // results
  output logic                                  done,
  output gcsf_pkg::result_word_t                result,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [gcsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gcsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import gcsf_pkg::*;

  // Mask of used leaf bits; leaf_count clamped to [2, LEAF_BITS].
  function automatic logic [SPLIT_W-1:0] leaf_mask(input logic [LEAF_W-1:0] lc);
    logic [LEAF_W:0]    n;
    logic [SPLIT_W-1:0] m;
    n = {1'b0, lc};
    if (n < (LEAF_W+1)'(2)) n = (LEAF_W+1)'(2);
    if (n > (LEAF_W+1)'(LEAF_BITS)) n = (LEAF_W+1)'(LEAF_BITS);
    for (int i = 0; i < SPLIT_W; i++) begin
      m[i] = ((LEAF_W+1)'(i) < n);
    end
    return m;
  endfunction

  // Four-gamete test: all of 11, 00, 10, 01 occur on the used leaves.
  function automatic logic gamete_clash(input logic [SPLIT_W-1:0] a,
                                        input logic [SPLIT_W-1:0] b,
                                        input logic [SPLIT_W-1:0] m);
    return (|(a & b & m)) && (|(~a & ~b & m)) &&
           (|(a & ~b & m)) && (|(~a & b & m));
  endfunction

  function automatic logic [SCNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    if (32'(c) > 127) return SCNT_W'(127);
    return SCNT_W'(c);
  endfunction

  // configuration registers
  logic [OCC_W-1:0]  threshold;
  logic              ext_mode;
  logic [LEAF_W-1:0] leaf_count;

  // control state
  gcsf_state_t       state, state_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic              majority_done, majority_done_next;
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;
  logic              chk_valid, chk_valid_next;   // store read in flight
  logic              clash, clash_next;
  logic              done_next;

  // payload held during a scan
  logic [SPLIT_W-1:0] split_reg, split_reg_next;
  logic [SPLIT_W-1:0] mask_reg, mask_reg_next;
  result_word_t       result_next;

  // store port
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [SPLIT_W-1:0] wr_data;
  logic [SPLIT_W-1:0] rd_data;

  // accept-cycle decode
  logic [SPLIT_W-1:0] cur_mask;
  logic [SPLIT_W-1:0] cur_split;
  logic [CNT_W-1:0]   eff_count;
  logic               eff_done;

  assign busy      = (state != ST_IDLE);
  assign cur_mask  = leaf_mask(leaf_count);
  assign cur_split = split_in.split_bits & cur_mask;
  assign eff_count = split_in.new_set ? '0 : entry_count;
  assign eff_done  = split_in.new_set ? 1'b0 : majority_done;

  gcsf_ram #(
    .WIDTH (SPLIT_W),
    .DEPTH (MAX_SPLITS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      ext_mode   <= 1'b1;
      leaf_count <= LEAF_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold  <= cfg_data[OCC_W-1:0];
        REG_EXT_MODE:  ext_mode   <= cfg_data[0];
        REG_LEAF_CNT:  leaf_count <= cfg_data[LEAF_W-1:0];
        default: ;   // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      majority_done <= 1'b0;
      rd_idx        <= '0;
      chk_valid     <= 1'b0;
      clash         <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      majority_done <= majority_done_next;
      rd_idx        <= rd_idx_next;
      chk_valid     <= chk_valid_next;
      clash         <= clash_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    split_reg <= split_reg_next;
    mask_reg  <= mask_reg_next;
    result    <= result_next;
  end

  always_comb begin
    state_next         = state;
    entry_count_next   = entry_count;
    majority_done_next = majority_done;
    rd_idx_next        = rd_idx;
    chk_valid_next     = 1'b0;
    clash_next         = clash;
    done_next          = 1'b0;
    split_reg_next     = split_reg;
    mask_reg_next      = mask_reg;
    result_next        = result;
    wr_en              = 1'b0;
    wr_addr            = entry_count[ADDR_W-1:0];
    wr_data            = split_reg;

    case (state)
      ST_IDLE: begin
        if (start) begin
          entry_count_next   = eff_count;
          majority_done_next = eff_done;
          split_reg_next     = cur_split;
          mask_reg_next      = cur_mask;
          wr_addr            = eff_count[ADDR_W-1:0];
          wr_data            = cur_split;
          if (!eff_done && (split_in.occurrence > threshold)) begin
            // majority phase: store unless full
            done_next = 1'b1;
            if (eff_count >= CNT_W'(MAX_SPLITS)) begin
              result_next = '{1'b0, VERD_FULL, sat_count(eff_count)};
            end else begin
              wr_en            = 1'b1;
              entry_count_next = eff_count + CNT_W'(1);
              result_next = '{1'b1, VERD_MAJORITY, sat_count(entry_count_next)};
            end
          end else begin
            majority_done_next = 1'b1;
            if (!ext_mode) begin
              done_next   = 1'b1;
              result_next = '{1'b0, VERD_BELOW_THR, sat_count(eff_count)};
            end else if (eff_count == '0) begin
              // nothing to test against; store at entry 0
              done_next        = 1'b1;
              wr_en            = 1'b1;
              entry_count_next = CNT_W'(1);
              result_next = '{1'b1, VERD_COMPATIBLE, sat_count(entry_count_next)};
            end else begin
              state_next  = ST_SCAN;
              rd_idx_next = '0;
              clash_next  = 1'b0;
            end
          end
        end
      end

      ST_SCAN: begin
        // check the entry read last cycle
        if (chk_valid && gamete_clash(rd_data, split_reg, mask_reg)) begin
          clash_next = 1'b1;
        end
        if (rd_idx < entry_count) begin
          rd_idx_next    = rd_idx + CNT_W'(1);
          chk_valid_next = 1'b1;
        end else if (!chk_valid) begin
          // all entries checked
          state_next = ST_IDLE;
          done_next  = 1'b1;
          if (clash) begin
            result_next = '{1'b0, VERD_CONFLICT, sat_count(entry_count)};
          end else if (entry_count >= CNT_W'(MAX_SPLITS)) begin
            result_next = '{1'b0, VERD_FULL, sat_count(entry_count)};
          end else begin
            wr_en            = 1'b1;
            entry_count_next = entry_count + CNT_W'(1);
            result_next = '{1'b1, VERD_COMPATIBLE, sat_count(entry_count_next)};
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/gcsf_ram.sv @@
// ----------------------------------------------------------------------------
// gcsf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/gcsf_checker.sv @@
// ----------------------------------------------------------------------------
// gcsf_checker: port-level checks for the split filter core
// Watches the core's ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gcsf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire gcsf_pkg::split_word_t           split_in,
  input wire logic                            done,
  input wire gcsf_pkg::result_word_t          result
);

  import gcsf_pkg::*;

  // an accepted word either finishes at once or starts a scan
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted word neither finished nor started a scan");

  // a new set starts from an empty store, so it never scans
  a_new_set_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && split_in.new_set) |=>
      (done && result.stored_count <= SCNT_W'(1)))
    else $error("new set word did not finish at once from an empty store");

  a_stored_verdict: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |->
      (result.verdict == VERD_MAJORITY || result.verdict == VERD_COMPATIBLE))
    else $error("stored split with a rejecting verdict");

  a_reject_verdict: assert property (@(posedge clk) disable iff (rst)
    (done && !result.accepted) |->
      (result.verdict == VERD_BELOW_THR || result.verdict == VERD_CONFLICT ||
       result.verdict == VERD_FULL))
    else $error("rejected split with a storing verdict");

  a_stored_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |-> (result.stored_count != '0))
    else $error("stored split but count is zero");

endmodule

bind greedy_compatible_split_filter_core gcsf_checker u_gcsf_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .split_in  (split_in),
  .done      (done),
  .result    (result)
);

`default_nettype wire

@@ dv/greedy_compatible_split_filter_core_test.sv @@
// ----------------------------------------------------------------------------
// greedy_compatible_split_filter_core_test: self-checking bench for the filter
// Feeds sets of split words with descending counts and predicts every verdict
// with an in-bench consensus tracker. Settings change between sets while the
// core is idle. Both the sender gaps and the content are random.
// ----------------------------------------------------------------------------

module greedy_compatible_split_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gcsf_pkg::*;

  // Tracks the consensus set the core should hold and the verdict each accepted
  // split word should produce; results are checked in order of acceptance.
  class split_consensus_tracker;
    logic [63:0]  held_splits [gcsf_pkg::MAX_SPLITS];
    int           held_count;
    bit           minority_phase;
    logic [15:0]  thr_reg = 16'd0;
    logic         ext_reg = 1'b1;
    logic [6:0]   leaf_reg = 7'd64;

    gcsf_pkg::result_word_t expected_verdicts [$];
    int errors;
    int checked;
    int verdict_hits [5];

    function int leaves_used();
      int n;
      n = leaf_reg;
      if (n < 2) n = 2;
      if (n > gcsf_pkg::LEAF_BITS) n = gcsf_pkg::LEAF_BITS;
      return n;
    endfunction

    function logic [63:0] leaf_mask();
      int n;
      n = leaves_used();
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    function void write_reg(logic [gcsf_pkg::CFG_IDX_W-1:0] idx,
                            logic [gcsf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gcsf_pkg::REG_THRESHOLD: thr_reg = data;
        gcsf_pkg::REG_EXT_MODE:  ext_reg = data[0];
        gcsf_pkg::REG_LEAF_CNT:  leaf_reg = data[6:0];
        default: ;
      endcase
    endfunction

    function bit gametes_clash(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      return ((a & b & m) != 0) && ((~a & ~b & m) != 0) &&
             ((a & ~b & m) != 0) && ((~a & b & m) != 0);
    endfunction

    // Accepted split word: update the consensus set, queue the verdict.
    function void take_split(gcsf_pkg::split_word_t w);
      logic [63:0] m;
      logic [63:0] s;
      gcsf_pkg::verdict_t v;
      gcsf_pkg::result_word_t r;
      bit keep;
      bit clash;
      m = leaf_mask();
      s = w.split_bits & m;
      keep = 1'b0;
      if (w.new_set) begin
        held_count = 0;
        minority_phase = 1'b0;
      end
      if (!minority_phase && w.occurrence > thr_reg) begin
        v = gcsf_pkg::VERD_MAJORITY;
        keep = 1'b1;
      end else begin
        minority_phase = 1'b1;
        if (!ext_reg) begin
          v = gcsf_pkg::VERD_BELOW_THR;
        end else begin
          clash = 1'b0;
          for (int k = 0; k < held_count; k++)
            if (gametes_clash(held_splits[k], s, m)) clash = 1'b1;
          if (clash) begin
            v = gcsf_pkg::VERD_CONFLICT;
          end else begin
            v = gcsf_pkg::VERD_COMPATIBLE;
            keep = 1'b1;
          end
        end
      end
      if (keep && held_count >= gcsf_pkg::MAX_SPLITS) begin
        keep = 1'b0;
        v = gcsf_pkg::VERD_FULL;
      end
      if (keep) begin
        held_splits[held_count] = s;
        held_count++;
      end
      r.accepted = keep;
      r.verdict = v;
      r.stored_count = (held_count > 127) ? 7'd127 : 7'(held_count);
      expected_verdicts.push_back(r);
    endfunction

    function void check_verdict(gcsf_pkg::result_word_t got);
      gcsf_pkg::result_word_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result word with no split pending, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      checked++;
      if (want.verdict < 5) verdict_hits[want.verdict]++;
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted mismatch, expected %0d, actual %0d",
                 $time, want.accepted, got.accepted);
        errors++;
      end
      if (got.verdict !== want.verdict) begin
        $display("%0t: verdict mismatch, expected %0d, actual %0d",
                 $time, want.verdict, got.verdict);
        errors++;
      end
      if (got.stored_count !== want.stored_count) begin
        $display("%0t: stored_count mismatch, expected %0d, actual %0d",
                 $time, want.stored_count, got.stored_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  localparam int ITEMS_TOTAL = 1350;
  localparam int CYCLE_LIMIT = 1_000_000;
  // index 3 decodes to no register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  split_word_t split_in;
  logic done;
  result_word_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  split_consensus_tracker tracker = new;
  int words_sent;
  int settings_applied;
  int cycle_count;

  greedy_compatible_split_filter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .split_in  (split_in),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: generous bound over the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[greedy_compatible_split_filter_core] ERROR");
      $finish;
    end
  end

  // Sample at the rising edge. A result word leaving at this edge belongs to
  // an older split, so it is checked before a newly accepted word is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_verdict(result);
      if (start && !busy) tracker.take_split(split_in);
    end
  end

  // Present one word and hold it until the core takes it. busy is looked at
  // on the falling edge, where it is settled, so the next rising edge takes
  // the word. start stays high on return so a back-to-back word does not
  // glitch it.
  task automatic send_split(input logic [63:0] bits, input int occ, input bit fresh);
    split_in.split_bits = bits;
    split_in.occurrence = occ[15:0];
    split_in.new_set = fresh;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Sender gap; junk on the payload while start is low.
  task automatic idle_sender(input int n);
    if (n == 0) return;
    start = 1'b0;
    split_in.split_bits = {$urandom, $urandom};
    split_in.occurrence = 16'($urandom);
    split_in.new_set = 1'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Wait until every expected word has come back and the core is idle.
  task automatic drain();
    start = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called while the core is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = CFG_DATA_W'($urandom);
    settings_applied++;
  endtask

  // New random setting, extremes weighted in. Unused data bits are random.
  task automatic random_setting();
    int r;
    logic [15:0] thr;
    logic [6:0] leaves;
    r = $urandom_range(5, 0);
    case (r)
      0: thr = 16'd0;
      1: thr = 16'hFFFF;
      2: thr = 16'd1;
      3: thr = 16'($urandom_range(200, 0));
      4: thr = 16'hFFFE;
      default: thr = 16'($urandom_range(65535, 0));
    endcase
    r = $urandom_range(11, 0);
    case (r)
      0: leaves = 7'd0;
      1: leaves = 7'd1;
      2: leaves = 7'd2;
      3: leaves = 7'd3;
      4: leaves = 7'd4;
      5: leaves = 7'd8;
      6: leaves = 7'd63;
      7: leaves = 7'd65;
      8: leaves = 7'd127;
      9: leaves = 7'($urandom_range(64, 2));
      default: leaves = 7'd64;
    endcase
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_EXT_MODE, {15'($urandom), 1'($urandom_range(3, 0) != 0)});
    write_reg(REG_LEAF_CNT, {9'($urandom), leaves});
    if ($urandom_range(7, 0) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom));
  endtask

  // Split content: aligned blocks nest or are disjoint (always compatible),
  // plain intervals mix compatible and clashing, raw words mostly clash.
  function automatic logic [63:0] make_split();
    int leaves;
    int lo;
    int len;
    int size;
    int r;
    logic [63:0] ones;
    logic [63:0] s;
    leaves = tracker.leaves_used();
    r = $urandom_range(9, 0);
    if (r < 4) begin
      size = 1 << $urandom_range(6, 0);
      while (size > leaves) size = size / 2;
      lo = size * $urandom_range(leaves / size - 1, 0);
      len = size;
    end else if (r < 7) begin
      lo = $urandom_range(leaves - 1, 0);
      len = $urandom_range(leaves - lo, 1);
    end else begin
      lo = 0;
      len = 0;
    end
    if (r == 9) begin
      s = ($urandom_range(1, 0) != 0) ? '1 : '0;
    end else if (len == 0) begin
      s = {$urandom, $urandom};
    end else begin
      ones = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
      s = ones << lo;
    end
    // bits above the used leaves are don't-care for the core
    if ($urandom_range(1, 0) != 0) s = s | ({$urandom, $urandom} & ~tracker.leaf_mask());
    return s;
  endfunction

  // One consensus set: a new_set word, a majority run with descending
  // counts, then minority words. Noise sets scramble counts and new_set.
  task automatic run_set();
    int n_maj;
    int n_min;
    int occ_cur;
    int thr;
    int occ;
    bit noise;
    bit no_gaps;
    bit fresh;
    thr = tracker.thr_reg;
    noise = ($urandom_range(9, 0) == 0);
    no_gaps = ($urandom_range(3, 0) == 0);
    if ($urandom_range(9, 0) == 0) begin
      n_maj = $urandom_range(70, 60);   // around the store depth, often enough to fill it
      n_min = $urandom_range(12, 2);
    end else begin
      n_maj = $urandom_range(12, 0);
      n_min = $urandom_range(40, 1);
    end
    if (thr >= 65535) n_maj = 0;
    occ_cur = thr + 1 + $urandom_range(65534 - thr, 0);
    for (int j = 0; j < n_maj; j++) begin
      fresh = (j == 0);
      occ = occ_cur;
      if (noise) begin
        occ = $urandom_range(65535, 0);
        fresh = ($urandom_range(9, 0) == 0);
      end
      if (!no_gaps) idle_sender(pick_gap());
      if ($urandom_range(39, 0) == 0) drain();
      send_split(make_split(), occ, fresh);
      occ_cur = occ_cur - $urandom_range((occ_cur - thr - 1) / 4, 0);
    end
    occ_cur = thr;
    for (int j = 0; j < n_min; j++) begin
      fresh = (n_maj == 0 && j == 0);
      occ = occ_cur;
      // once the majority run ends, a high count must no longer matter
      if ($urandom_range(7, 0) == 0) occ = $urandom_range(65535, 0);
      if (noise) begin
        occ = $urandom_range(65535, 0);
        fresh = ($urandom_range(9, 0) == 0);
      end
      if (!no_gaps) idle_sender(pick_gap());
      if ($urandom_range(39, 0) == 0) drain();
      send_split(make_split(), occ, fresh);
      occ_cur = occ_cur - $urandom_range(occ_cur / 4, 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    split_in = '0;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset setting (threshold 0, extended, 64 leaves).
    send_split('1, 16'hFFFF, 1'b1);
    send_split('0, 1, 1'b0);
    send_split(64'h0000_0000_FFFF_FFFF, 1, 1'b0);
    send_split(64'h5555_5555_5555_5555, 0, 1'b0);           // clashes
    send_split(64'hFFFF_0000_0000_0000, 16'hFFFF, 1'b0);    // count ignored now
    send_split(64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);

    // Unreachable threshold, plain mode (upper data bits ignored).
    drain();
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_EXT_MODE, 16'hFFFE);
    send_split(64'h8000_0000_0000_0001, 16'hFFFF, 1'b1);
    send_split('0, 0, 1'b0);

    // Leaf count below range behaves as 2 leaves.
    drain();
    write_reg(REG_EXT_MODE, 16'h0001);
    write_reg(REG_LEAF_CNT, 16'h0000);
    send_split(64'hFFFF_FFFF_FFFF_FFFD, 16'hFFFF, 1'b1);
    send_split(64'hFFFF_FFFF_FFFF_FFFE, 0, 1'b0);
    send_split(64'h0000_0000_0000_0003, 0, 1'b0);
    drain();
    write_reg(REG_LEAF_CNT, 16'hFF81);
    send_split({$urandom, $urandom}, 0, 1'b1);

    // Leaf count above range behaves as 64.
    drain();
    write_reg(REG_LEAF_CNT, 16'd127);
    write_reg(REG_THRESHOLD, 16'd0);
    send_split({$urandom, $urandom}, 1, 1'b1);
    send_split({$urandom, $urandom}, 0, 1'b0);

    // Five leaves: masked-off bits, a clash and a disjoint compatible split.
    drain();
    write_reg(REG_LEAF_CNT, 16'd5);
    send_split(64'hFFFF_FFFF_FFFF_FFE3, 9, 1'b1);
    send_split(64'h0000_0000_0000_0006, 0, 1'b0);
    drain();
    write_reg(REG_NONE, 16'hFFFF);
    send_split(64'h0000_0000_0000_0018, 0, 1'b0);

    // Random sets, setting changed every few sets while idle.
    drain();
    random_setting();
    while (words_sent < ITEMS_TOTAL) begin
      if ($urandom_range(2, 0) == 0) begin
        drain();
        random_setting();
      end
      run_set();
    end

    drain();
    repeat (MAX_SPLITS + 4) @(negedge clk);

    $display("checked %0d split words under %0d register writes",
             tracker.checked, settings_applied);
    $display("verdicts: %0d majority, %0d compatible, %0d plain, %0d clash, %0d full",
             tracker.verdict_hits[VERD_MAJORITY], tracker.verdict_hits[VERD_COMPATIBLE],
             tracker.verdict_hits[VERD_BELOW_THR], tracker.verdict_hits[VERD_CONFLICT],
             tracker.verdict_hits[VERD_FULL]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[greedy_compatible_split_filter_core] OK");
    end else begin
      $display("[greedy_compatible_split_filter_core] ERROR");
    end
    $finish;
  end

endmodule

@@ greedy_compatible_split_filter_core.f @@
src/gcsf_pkg.sv
src/gcsf_ram.sv
src/greedy_compatible_split_filter_core.sv
src/gcsf_checker.sv
dv/greedy_compatible_split_filter_core_test.sv
